// File: rtl/core/mt_pkg.sv
// Shared constants and types for the MT19937 random word generator.
package mt_pkg;

    // Word width of the generator state and output.
    localparam int WORD_W = 32;

    // Default table geometry.
    localparam int STATE_WORDS_DEF   = 624;
    localparam int MIDDLE_OFFSET_DEF = 397;

    // Recurrence and tempering constants.
    localparam logic [WORD_W-1:0] DEFAULT_SEED  = 32'd5489;
    localparam logic [WORD_W-1:0] TWIST_MATRIX  = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_MASK_B = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_MASK_C = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] INIT_MULT     = 32'h6c07_8965;
    localparam logic [WORD_W-1:0] UPPER_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_BITS    = 32'h7fff_ffff;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_TW_PRIME,
        S_TW_RD,
        S_TW_WR,
        S_GEN_RD,
        S_GEN_OUT
    } state_t;

endpackage

// File: rtl/core/mt19937_random_generator_top.sv
// MT19937 generator: state table in a 2-read/1-write memory, sequenced update.
// Seed command: busy while refilling (one table word written per cycle), no result.
// Generate command: a read state, then an output state whose word and strobe are registered;
// busy meanwhile; a used-up table first runs a twist (one read and one write state per word).
// Reset: the table is refilled from seed 5489 with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module mt19937_random_generator_top
    import mt_pkg::*;
#(
    parameter int STATE_WORDS   = STATE_WORDS_DEF,
    parameter int MIDDLE_OFFSET = MIDDLE_OFFSET_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [WORD_W-1:0] seed_value,
    output logic              result_valid,
    output logic [WORD_W-1:0] random_word
);

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam int POS_W  = $clog2(STATE_WORDS + 1);

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STATE_WORDS - 1);
    localparam logic [POS_W-1:0]  POS_FULL = POS_W'(STATE_WORDS);

    // Control and data registers.
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [WORD_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] word_reg, word_next;

    // Memory ports.
    logic [WORD_W-1:0] mem [STATE_WORDS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [WORD_W-1:0] rdata_a_reg;
    logic [WORD_W-1:0] rdata_b_reg;

    // Datapath helpers.
    logic [2*WORD_W-1:0] fill_prod;
    logic [WORD_W-1:0]   fill_word;
    logic [ADDR_W:0]     mid_sum;
    logic [ADDR_W-1:0]   mid_idx;
    logic [ADDR_W-1:0]   next_idx;
    logic [WORD_W-1:0]   twist_y;
    logic [WORD_W-1:0]   twist_word;
    logic [WORD_W-1:0]   tempered;

    // Seeding recurrence: one multiply and one add per table word.
    assign fill_prod = INIT_MULT * (prev_reg ^ (prev_reg >> 30));
    assign fill_word = fill_prod[WORD_W-1:0] + WORD_W'(idx_reg);

    // Neighbor and middle indexes of the current twist word, wrapped once.
    assign mid_sum  = {1'b0, idx_reg} + (ADDR_W+1)'(MIDDLE_OFFSET);
    assign mid_idx  = (mid_sum >= (ADDR_W+1)'(STATE_WORDS))
                      ? ADDR_W'(mid_sum - (ADDR_W+1)'(STATE_WORDS))
                      : mid_sum[ADDR_W-1:0];
    assign next_idx = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // Twist of one word from its upper bit, the neighbor's lower bits and the middle word.
    assign twist_y    = (cur_reg & UPPER_BIT) | (rdata_a_reg & LOWER_BITS);
    assign twist_word = rdata_b_reg ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

    mt_temper u_temper (
        .word_in  (rdata_a_reg),
        .word_out (tempered)
    );

    // State table: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            idx_reg   <= '0;
            pos_reg   <= POS_FULL;
            seed_reg  <= DEFAULT_SEED;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            seed_reg  <= seed_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        word_reg <= word_next;
    end

    // Sequencer: next state, memory control and datapath selects.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        seed_next  = seed_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        valid_next = 1'b0;
        word_next  = word_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = twist_word;
        raddr_a    = idx_reg;
        raddr_b    = mid_idx;

        case (state_reg)
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = (idx_reg == '0) ? seed_reg : fill_word;
                prev_next = mem_wdata;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    pos_next   = POS_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    if (kind)
                    begin
                        seed_next  = seed_value;
                        state_next = S_FILL;
                    end
                    else if (pos_reg == POS_FULL)
                    begin
                        state_next = S_TW_PRIME;
                    end
                    else
                    begin
                        state_next = S_GEN_RD;
                    end
                end
            end
            S_TW_PRIME:
            begin
                // Fetch word 0, the first current word of the twist.
                state_next = S_TW_RD;
            end
            S_TW_RD:
            begin
                raddr_a = next_idx;
                raddr_b = mid_idx;
                if (idx_reg == '0)
                begin
                    cur_next = rdata_a_reg;
                end
                state_next = S_TW_WR;
            end
            S_TW_WR:
            begin
                mem_we   = 1'b1;
                cur_next = rdata_a_reg;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    pos_next   = '0;
                    state_next = S_GEN_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TW_RD;
                end
            end
            S_GEN_RD:
            begin
                raddr_a    = pos_reg[ADDR_W-1:0];
                state_next = S_GEN_OUT;
            end
            S_GEN_OUT:
            begin
                word_next  = tempered;
                valid_next = 1'b1;
                pos_next   = pos_reg + 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign random_word  = word_reg;

    // A command taken in idle always leaves idle on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command accepted without leaving idle");

    // The table is written only while seeding or twisting.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_FILL || state_reg == S_TW_WR))
        else $error("table written outside seeding or twist");

    // The read position never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FULL)
        else $error("read position beyond table");

    // A result strobe follows the output stage of a generate command only.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) == S_GEN_OUT)
        else $error("result strobe without a generate command");

endmodule

// File: rtl/core/mt_temper.sv
// Output tempering transform applied to a raw state word.
module mt_temper
    import mt_pkg::*;
(
    input  logic [WORD_W-1:0] word_in,
    output logic [WORD_W-1:0] word_out
);

    logic [WORD_W-1:0] y1;
    logic [WORD_W-1:0] y2;
    logic [WORD_W-1:0] y3;

    // Four shift-and-mask steps of the standard tempering.
    always_comb
    begin
        y1       = word_in ^ (word_in >> 11);
        y2       = y1 ^ ((y1 << 7) & TEMPER_MASK_B);
        y3       = y2 ^ ((y2 << 15) & TEMPER_MASK_C);
        word_out = y3 ^ (y3 >> 18);
    end

endmodule
